// ===== sv/sra_pkg.sv =====
`default_nettype none

package sra_pkg;

  // Command codes of an input word
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_EXISTING = 2'd0;
  localparam logic [1:0] STATUS_NEW      = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;
  localparam logic [1:0] STATUS_CLEARED  = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] CFG_ATLAS_WIDTH  = 8'd0;
  localparam logic [7:0] CFG_ATLAS_HEIGHT = 8'd1;

  // One shelf entry of the shelf store
  typedef struct packed {
    logic [12:0] used_width;
    logic [12:0] row_height;
    logic [10:0] slot_count;
  } shelf_word_t;

  typedef enum logic [2:0] {
    SEQ_IDLE   = 3'b001,
    SEQ_SCAN   = 3'b010,
    SEQ_COMMIT = 3'b100
  } seq_state_e;

endpackage

`default_nettype wire

// ===== sv/sra_ram.sv =====
`default_nettype none

module sra_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/shelf_rect_allocator.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// command   in         start_i / busy_o          command_i, item_width_i, item_height_i
// result    out        done_o (one-cycle strobe) status_o, shelf_index_o, slot_index_o,
//                                                pos_x_o, pos_y_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A clear or an early reject (item table full, item wider than atlas) is answered from idle:
// the result strobes the cycle after start and busy_o never rises.
// An add keeps busy_o high while the sequencer scans (one read of the shelf RAM per
// shelf in use, the RAM read latency, a step to close the scan) and then commits;
// with no shelf open the scan only closes. The result strobes the cycle after commit.
// busy_o falls in the cycle that done_o strobes, so the next word may start then.
// cfg_ready_o is high only while the sequencer idles and start_i is low.
// Reset clears the sequencer, the shelf and item counts and both atlas registers;
// the shelf RAM itself is not cleared, entries past the shelf count are never read.
// The receiver cannot stall: each result is valid for exactly the done_o cycle.

module shelf_rect_allocator #(
  parameter int SHELF_DEPTH = 256,
  parameter int ITEM_LIMIT  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [12:0] item_width_i,
  input  wire logic [12:0] item_height_i,

  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [7:0]       shelf_index_o,
  output logic [9:0]       slot_index_o,
  output logic [11:0]      pos_x_o,
  output logic [11:0]      pos_y_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  // Shelf address, shelf count, item count, prefix-sum and shelf word widths
  localparam int SW = (SHELF_DEPTH > 1) ? $clog2(SHELF_DEPTH) : 1;
  localparam int CW = $clog2(SHELF_DEPTH + 1);
  localparam int PW = $clog2(ITEM_LIMIT + 1);
  localparam int RW = 13 + $clog2(SHELF_DEPTH);
  localparam int DW = $bits(sra_pkg::shelf_word_t);

  sra_pkg::seq_state_e state_q, state_d;

  logic [12:0]   aw_q, aw_d;
  logic [12:0]   ah_q, ah_d;
  logic [12:0]   iw_q, iw_d;
  logic [12:0]   ih_q, ih_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] placed_q, placed_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [SW-1:0] tag_q, tag_d;
  logic [RW-1:0] reserved_q, reserved_d;
  logic          found_q, found_d;
  logic [SW-1:0] best_idx_q, best_idx_d;
  logic [12:0]   best_h_q, best_h_d;
  logic [12:0]   best_x_q, best_x_d;
  logic [10:0]   best_slot_q, best_slot_d;
  logic [11:0]   best_y_q, best_y_d;

  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  shelf_q, shelf_d;
  logic [9:0]  slot_q, slot_d;
  logic [11:0] x_q, x_d;
  logic [11:0] y_q, y_d;

  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;
  sra_pkg::shelf_word_t ram_wdata;
  sra_pkg::shelf_word_t ram_rdata;
  logic [DW-1:0]        ram_rdata_raw;

  logic          accept;
  logic          more;
  logic          fit;
  logic          room;
  logic [13:0]   right_edge;

  sra_ram #(
    .WIDTH (DW),
    .DEPTH (SHELF_DEPTH)
  ) u_shelf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[SW-1:0]),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata   = sra_pkg::shelf_word_t'(ram_rdata_raw);
  assign busy_o      = (state_q != sra_pkg::SEQ_IDLE);
  assign cfg_ready_o = (state_q == sra_pkg::SEQ_IDLE) && !start_i;
  assign accept      = start_i && !busy_o;
  assign more        = (ptr_q < count_q);

  // Shelf fit test on the entry returned by the RAM
  assign right_edge = 14'(iw_q) + 14'(ram_rdata.used_width);
  assign fit = (right_edge <= 14'(aw_q)) && (ih_q <= ram_rdata.row_height) &&
               (ram_rdata.row_height < best_h_q);

  // Enough height left below the open shelves for a new one, and a free shelf entry
  assign room = ((RW+1)'(reserved_q) + (RW+1)'(ih_q) <= (RW+1)'(ah_q)) &&
                (count_q < CW'(SHELF_DEPTH));

  always_comb begin
    state_d     = state_q;
    aw_d        = aw_q;
    ah_d        = ah_q;
    iw_d        = iw_q;
    ih_d        = ih_q;
    count_d     = count_q;
    placed_d    = placed_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    tag_d       = tag_q;
    reserved_d  = reserved_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_h_d    = best_h_q;
    best_x_d    = best_x_q;
    best_slot_d = best_slot_q;
    best_y_d    = best_y_q;
    done_d      = 1'b0;
    status_d    = status_q;
    shelf_d     = shelf_q;
    slot_d      = slot_q;
    x_d         = x_q;
    y_d         = y_q;
    ram_we      = 1'b0;
    ram_waddr   = best_idx_q;
    ram_wdata   = '0;

    // Atlas registers; only written while idle
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == sra_pkg::CFG_ATLAS_WIDTH) begin
        aw_d = cfg_data_i;
      end else if (cfg_index_i == sra_pkg::CFG_ATLAS_HEIGHT) begin
        ah_d = cfg_data_i;
      end
    end

    case (state_q)
      sra_pkg::SEQ_IDLE: begin
        if (accept) begin
          iw_d = item_width_i;
          ih_d = item_height_i;
          if (command_i == sra_pkg::CMD_CLEAR) begin
            // Drop all shelves and items at once
            count_d  = '0;
            placed_d = '0;
            done_d   = 1'b1;
            status_d = sra_pkg::STATUS_CLEARED;
            shelf_d  = '0;
            slot_d   = '0;
            x_d      = '0;
            y_d      = '0;
          end else if ((placed_q >= PW'(ITEM_LIMIT)) || (item_width_i > aw_q)) begin
            done_d   = 1'b1;
            status_d = sra_pkg::STATUS_NO_ROOM;
            shelf_d  = '0;
            slot_d   = '0;
            x_d      = '0;
            y_d      = '0;
          end else begin
            ptr_d      = '0;
            pend_d     = 1'b0;
            reserved_d = '0;
            found_d    = 1'b0;
            best_h_d   = ah_q;
            state_d    = sra_pkg::SEQ_SCAN;
          end
        end
      end

      sra_pkg::SEQ_SCAN: begin
        // Issue the next shelf read
        if (more) begin
          ptr_d  = ptr_q + CW'(1);
          pend_d = 1'b1;
          tag_d  = ptr_q[SW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        // Evaluate the shelf read last cycle
        if (pend_q) begin
          reserved_d = reserved_q + RW'(ram_rdata.row_height);
          if (fit) begin
            found_d     = 1'b1;
            best_idx_d  = tag_q;
            best_h_d    = ram_rdata.row_height;
            best_x_d    = ram_rdata.used_width;
            best_slot_d = ram_rdata.slot_count;
            best_y_d    = reserved_q[11:0];
          end
        end
        if (!more && !pend_q) begin
          state_d = sra_pkg::SEQ_COMMIT;
        end
      end

      sra_pkg::SEQ_COMMIT: begin
        done_d  = 1'b1;
        state_d = sra_pkg::SEQ_IDLE;
        if (found_q) begin
          // Widen the chosen shelf
          ram_we               = 1'b1;
          ram_waddr            = best_idx_q;
          ram_wdata.used_width = 13'(best_x_q + iw_q);
          ram_wdata.row_height = best_h_q;
          ram_wdata.slot_count = best_slot_q + 11'd1;
          placed_d             = placed_q + PW'(1);
          status_d             = sra_pkg::STATUS_EXISTING;
          shelf_d              = 8'(best_idx_q);
          slot_d               = best_slot_q[9:0];
          x_d                  = best_x_q[11:0];
          y_d                  = best_y_q;
        end else if (room) begin
          // Open a new shelf below the others; a zero-height shelf stays unused
          ram_we               = 1'b1;
          ram_waddr            = count_q[SW-1:0];
          ram_wdata.used_width = iw_q;
          ram_wdata.row_height = ih_q;
          ram_wdata.slot_count = 11'd1;
          if (ih_q != 13'd0) begin
            count_d = count_q + CW'(1);
          end
          placed_d = placed_q + PW'(1);
          status_d = sra_pkg::STATUS_NEW;
          shelf_d  = 8'(count_q);
          slot_d   = '0;
          x_d      = '0;
          y_d      = reserved_q[11:0];
        end else begin
          status_d = sra_pkg::STATUS_NO_ROOM;
          shelf_d  = '0;
          slot_d   = '0;
          x_d      = '0;
          y_d      = '0;
        end
      end

      default: begin
        state_d = sra_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sra_pkg::SEQ_IDLE;
      aw_q     <= '0;
      ah_q     <= '0;
      count_q  <= '0;
      placed_q <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      aw_q     <= aw_d;
      ah_q     <= ah_d;
      count_q  <= count_d;
      placed_q <= placed_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  // Payload and scan data registers hold without reset
  always_ff @(posedge clk_i) begin
    iw_q        <= iw_d;
    ih_q        <= ih_d;
    tag_q       <= tag_d;
    reserved_q  <= reserved_d;
    best_idx_q  <= best_idx_d;
    best_h_q    <= best_h_d;
    best_x_q    <= best_x_d;
    best_slot_q <= best_slot_d;
    best_y_q    <= best_y_d;
    status_q    <= status_d;
    shelf_q     <= shelf_d;
    slot_q      <= slot_d;
    x_q         <= x_d;
    y_q         <= y_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign shelf_index_o = shelf_q;
  assign slot_index_o  = slot_q;
  assign pos_x_o       = x_q;
  assign pos_y_o       = y_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // Sizes of the block's tables, as built with its default parameters
  localparam int SHELF_CAP = 256;
  localparam int ITEM_CAP  = 1024;

  // Quiet time after the last result: longest scan plus margin
  localparam int DRAIN_TAIL  = SHELF_CAP + 40;
  // Cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT = 5000;
  localparam int REPORT_MAX  = 10;

  localparam logic [12:0] ATLAS_MAX = 13'd4096;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  shelf;
    logic [9:0]  slot;
    logic [11:0] x;
    logic [11:0] y;
  } placement_t;

  // Scoreboard: keeps a private copy of the shelf store and the atlas size,
  // predicts the placement of every accepted word and checks results in order.
  class placement_board;
    logic [12:0] atlas_w;
    logic [12:0] atlas_h;
    logic [12:0] used_w [SHELF_CAP];
    logic [12:0] row_h  [SHELF_CAP];
    logic [10:0] slots  [SHELF_CAP];
    int          placed;
    placement_t  due[$];
    int          mismatches;
    int          checked;
    int          status_seen [4];

    function new();
      atlas_w    = '0;
      atlas_h    = '0;
      mismatches = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      empty_shelves();
    endfunction

    function void empty_shelves();
      foreach (used_w[i]) begin
        used_w[i] = '0;
        row_h[i]  = '0;
        slots[i]  = '0;
      end
      placed = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [12:0] data);
      if (idx == sra_pkg::CFG_ATLAS_WIDTH) begin
        atlas_w = data;
      end else if (idx == sra_pkg::CFG_ATLAS_HEIGHT) begin
        atlas_h = data;
      end
    endfunction

    // Best-height fit over the used shelves, else open a shelf at the bottom.
    function placement_t pack_rect(logic cmd, logic [12:0] w, logic [12:0] h);
      placement_t r;
      int  iw, ih, aw, remaining, reserved, best_h, best_y, idx, best;
      bit  found;
      r         = '0;
      iw        = int'(w);
      ih        = int'(h);
      aw        = int'(atlas_w);
      remaining = int'(atlas_h);
      reserved  = 0;
      best_h    = int'(atlas_h);
      best_y    = 0;
      best      = 0;
      found     = 1'b0;
      idx       = 0;
      if (cmd == sra_pkg::CMD_CLEAR) begin
        empty_shelves();
        r.status = sra_pkg::STATUS_CLEARED;
        return r;
      end
      r.status = sra_pkg::STATUS_NO_ROOM;
      // item table full, or wider than the whole atlas
      if (placed >= ITEM_CAP || iw > aw) return r;
      // a zero row height ends the used part of the store
      while (idx < SHELF_CAP && row_h[idx] != '0) begin
        remaining -= int'(row_h[idx]);
        reserved  += int'(row_h[idx]);
        if (iw <= aw - int'(used_w[idx]) && ih <= int'(row_h[idx]) &&
            int'(row_h[idx]) < best_h) begin
          best_h = int'(row_h[idx]);
          best   = idx;
          best_y = reserved - best_h;
          found  = 1'b1;
        end
        idx++;
      end
      if (found) begin
        r.status     = sra_pkg::STATUS_EXISTING;
        r.shelf      = best[7:0];
        r.slot       = slots[best][9:0];
        r.x          = used_w[best][11:0];
        r.y          = best_y[11:0];
        used_w[best] = used_w[best] + w;
        slots[best]  = slots[best] + 11'd1;
        placed++;
      end else if (remaining >= ih && idx < SHELF_CAP) begin
        r.status    = sra_pkg::STATUS_NEW;
        r.shelf     = idx[7:0];
        r.y         = reserved[11:0];
        used_w[idx] = w;
        row_h[idx]  = h;
        slots[idx]  = 11'd1;
        placed++;
      end
      return r;
    endfunction

    function void note_word(logic cmd, logic [12:0] w, logic [12:0] h);
      placement_t p;
      p = pack_rect(cmd, w, h);
      status_seen[p.status]++;
      due.push_back(p);
    endfunction

    function void check_placement(logic [1:0] st, logic [7:0] sh, logic [9:0] sl,
                                  logic [11:0] x, logic [11:0] y);
      placement_t want;
      checked++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result (status %0d) with no word outstanding", $time, st);
        return;
      end
      want = due.pop_front();
      if (st !== want.status || sh !== want.shelf || sl !== want.slot ||
          x !== want.x || y !== want.y) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("[%0t] mismatch (want/got): status %0d/%0d shelf %0d/%0d slot %0d/%0d",
                   $time, want.status, st, want.shelf, sh, want.slot, sl);
          $display("    x %0d/%0d y %0d/%0d", want.x, x, want.y, y);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic        command_i     = sra_pkg::CMD_ADD;
  logic [12:0] item_width_i  = '0;
  logic [12:0] item_height_i = '0;
  logic        cfg_valid_i   = 1'b0;
  logic [7:0]  cfg_index_i   = sra_pkg::CFG_ATLAS_WIDTH;
  logic [12:0] cfg_data_i    = '0;

  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  shelf_index_o;
  logic [9:0]  slot_index_o;
  logic [11:0] pos_x_o;
  logic [11:0] pos_y_o;
  logic        cfg_ready_o;

  placement_board book;

  int idle_pct      = 32;
  int words_sent    = 0;
  int settings_used = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  shelf_rect_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .item_width_i  (item_width_i),
    .item_height_i (item_height_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .shelf_index_o (shelf_index_o),
    .slot_index_o  (slot_index_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Monitor: everything is read at the edge, before this edge's updates land,
  // so each handshake is seen with the values the block saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) book.write_reg(cfg_index_i, cfg_data_i);
      if (done_o)
        book.check_placement(status_o, shelf_index_o, slot_index_o, pos_x_o, pos_y_o);
      if (start_i && !busy_o) book.note_word(command_i, item_width_i, item_height_i);
    end
  end

  // Offer one word; hold it until the block takes it. While idling, toss junk
  // on the payload so that sampling outside the handshake shows up.
  task automatic send_word(input logic cmd, input logic [12:0] w, input logic [12:0] h);
    while ($urandom_range(99) < idle_pct) begin
      start_i       <= 1'b0;
      command_i     <= 1'($urandom);
      item_width_i  <= 13'($urandom);
      item_height_i <= 13'($urandom);
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    command_i     <= cmd;
    item_width_i  <= w;
    item_height_i <= h;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    words_sent++;
    // sender idles a third of the time, then about half, then never
    idle_pct = (words_sent < 420) ? 32 : (words_sent < 840) ? 54 : 0;
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic settle_block();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (book.due.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  // Keep valid high across back-to-back writes; the caller drops it.
  task automatic put_reg(input logic [7:0] idx, input logic [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_atlas(input logic [12:0] w, input logic [12:0] h);
    settle_block();
    put_reg(sra_pkg::CFG_ATLAS_WIDTH, w);
    put_reg(sra_pkg::CFG_ATLAS_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Random add. Roomy: small rectangles that mostly land, with the odd
  // full-width or zero-sized one. Otherwise: anything, against a shrunk atlas.
  task automatic send_mixed(input bit roomy);
    int          pick;
    logic [12:0] w;
    logic [12:0] h;
    pick = $urandom_range(99);
    if (!roomy) begin
      w = pick[0] ? 13'($urandom_range(0, 4096)) : 13'($urandom_range(0, 400));
      h = pick[1] ? 13'($urandom_range(0, 4096)) : 13'($urandom_range(0, 400));
    end else if (pick < 5) begin
      w = 13'($urandom_range(0, 4096));
      h = 13'($urandom_range(0, 20));
    end else if (pick < 10) begin
      w = pick[0] ? 13'd0 : 13'($urandom_range(1, 96));
      h = pick[0] ? 13'($urandom_range(0, 20)) : 13'd0;
    end else begin
      w = 13'($urandom_range(1, 96));
      h = 13'($urandom_range(1, 20));
    end
    send_word(sra_pkg::CMD_ADD, w, h);
  endtask

  initial begin : stimulus
    int          round;
    int          fails;
    logic [12:0] wide;
    book = new();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Atlas registers still at their reset value of zero
    send_word(sra_pkg::CMD_ADD, 13'd0, 13'd0);      // zero-height shelf, stays unused
    send_word(sra_pkg::CMD_ADD, 13'd1, 13'd0);      // wider than a zero-width atlas
    send_word(sra_pkg::CMD_ADD, 13'd0, 13'd1);      // no height left
    send_word(sra_pkg::CMD_CLEAR, '0, '0);

    // Small atlas: fill, reuse, best fit, both kinds of refusal
    set_atlas(13'd100, 13'd50);
    send_word(sra_pkg::CMD_ADD, 13'd40, 13'd10);    // shelf 0
    send_word(sra_pkg::CMD_ADD, 13'd30, 13'd8);     // onto shelf 0
    send_word(sra_pkg::CMD_ADD, 13'd20, 13'd20);    // shelf 1 below it
    send_word(sra_pkg::CMD_ADD, 13'd40, 13'd5);     // shelf 0 too full, goes on shelf 1
    send_word(sra_pkg::CMD_ADD, 13'd10, 13'd5);     // shortest shelf that fits wins
    send_word(sra_pkg::CMD_ADD, 13'd101, 13'd1);    // wider than the atlas
    send_word(sra_pkg::CMD_ADD, 13'd10, 13'd25);    // taller than what is left
    send_word(sra_pkg::CMD_ADD, 13'd100, 13'd20);   // takes exactly the rest
    send_word(sra_pkg::CMD_ADD, 13'd5, 13'd0);      // zero height on an open shelf
    send_word(sra_pkg::CMD_ADD, 13'd30, 13'd20);
    send_word(sra_pkg::CMD_ADD, ATLAS_MAX, ATLAS_MAX);
    send_word(sra_pkg::CMD_CLEAR, '0, '0);

    // Full-size atlas: a shelf as tall as the atlas is never reused, and
    // coordinates of 4096 wrap to zero on the 12-bit outputs
    set_atlas(ATLAS_MAX, ATLAS_MAX);
    send_word(sra_pkg::CMD_ADD, ATLAS_MAX, ATLAS_MAX);
    send_word(sra_pkg::CMD_ADD, 13'd0, 13'd0);
    send_word(sra_pkg::CMD_ADD, 13'd0, 13'd1);
    send_word(sra_pkg::CMD_CLEAR, '0, '0);
    send_word(sra_pkg::CMD_ADD, 13'd2048, 13'd16);
    send_word(sra_pkg::CMD_ADD, 13'd2048, 13'd16);
    send_word(sra_pkg::CMD_ADD, 13'd0, 13'd16);
    send_word(sra_pkg::CMD_ADD, 13'd0, 13'd8);

    // Fill the shelf table: every item is more than half the atlas wide, so
    // each opens a shelf of its own until all of them are in use
    wide = 13'($urandom_range(3000, 4096));
    set_atlas(wide, ATLAS_MAX);
    send_word(sra_pkg::CMD_CLEAR, '0, '0);
    repeat (SHELF_CAP + 6)
      send_word(sra_pkg::CMD_ADD, 13'($urandom_range(wide / 2 + 1, wide)),
                13'($urandom_range(1, 20)));

    // Pack small rectangles into the free ends of those shelves until the
    // item table is full; one round shrinks the atlas under them
    round = 0;
    while (book.placed < ITEM_CAP && round < 16) begin
      if (round == 3) begin
        set_atlas('0, '0);
        repeat (25) send_mixed(1'b0);
        set_atlas(13'($urandom_range(1, 400)), 13'($urandom_range(1, 400)));
        repeat (25) send_mixed(1'b0);
      end else begin
        set_atlas(13'($urandom_range(3000, 4096)), ATLAS_MAX);
        repeat (100) send_mixed(1'b1);
      end
      round++;
    end
    repeat (40) send_mixed(1'b1);

    // Start over on a fresh store with a random atlas
    send_word(sra_pkg::CMD_CLEAR, '0, '0);
    set_atlas(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    repeat (60) send_mixed(1'b1);
    send_word(sra_pkg::CMD_CLEAR, '0, '0);

    settle_block();
    repeat (DRAIN_TAIL) @(posedge clk_i);

    fails = book.mismatches + book.due.size();
    if (book.due.size() != 0)
      $display("%0d expected results never arrived", book.due.size());
    $display("Run covered %0d words over %0d atlas settings, %0d results checked:",
             words_sent, settings_used, book.checked);
    $display("  %0d on open shelves, %0d on new shelves, %0d refused, %0d clears",
             book.status_seen[sra_pkg::STATUS_EXISTING],
             book.status_seen[sra_pkg::STATUS_NEW],
             book.status_seen[sra_pkg::STATUS_NO_ROOM],
             book.status_seen[sra_pkg::STATUS_CLEARED]);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: end the run if no word, result or register write moves for
  // too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
